[sv/dirt_pkg.sv]
// Package for the dense identifier renaming table.
// Holds the item structs, table entry layout and shared constants.
// No dependencies.
package dirt_pkg;

  localparam int ID_W      = 10;
  localparam int LIM_W     = 11;
  localparam int EPOCH_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [ID_W-1:0]    ID_MAX    = '1;
  localparam logic [LIM_W-1:0]   LIM_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TEMP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_LIMIT  = 1'b1;

  // Request codes
  localparam logic REQ_OPERAND = 1'b0;
  localparam logic REQ_FINISH  = 1'b1;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic            req_type;
    logic            is_variable;
    logic [ID_W-1:0] var_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  id_out;
    logic             id_changed;
    logic             newly_assigned;
    logic [LIM_W-1:0] new_var_limit;
    logic [LIM_W-1:0] var_gain;
  } out_item_t;

  // One table word: the epoch it was written in and the dense identifier
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [ID_W-1:0]    mapped;
  } tbl_entry_t;

  localparam int TBL_W = $bits(tbl_entry_t);

endpackage

[sv/dirt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Read during write to the same address returns the old contents.
// No dependencies.
module dirt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/dirt_rsp_fifo.sv]
// Small result queue between the lookup stage and the output channel.
// Depends on dirt_pkg for the result item type and queue geometry.
module dirt_rsp_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  dirt_pkg::out_item_t         push_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dirt_pkg::out_item_t         out_data,
  output logic [dirt_pkg::FIFO_CW-1:0] count
);
  import dirt_pkg::*;

  out_item_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/dense_id_renaming_table.sv]
// Top level of the dense identifier renaming table.
// Depends on dirt_pkg, dirt_ram and dirt_rsp_fifo.
//
// Usage:
//   in_valid/in_ready/in_data carry request items: an operand to rename or
//   a finish request. out_valid/out_ready/out_data carry exactly one result
//   item per request, in order. cfg_we/cfg_index/cfg_wdata write the
//   first-temporary identifier (index 0) and the old variable limit
//   (index 1); write them only while the block is idle.
//   Each request is accepted with its table read issued at once; in the next
//   cycle the table word (or the word written the cycle before, forwarded)
//   is checked, a new entry written back, and the result queued. Throughput
//   is one item per cycle while in_ready stays high, set by the single table
//   read-modify-write per operand. Entries carry an epoch tag, so a finish
//   clears the table by advancing the epoch. Every 63rd finish, and right after
//   reset, a clearing pass writes every table entry, one per cycle (MAX_VARS
//   entries, capped at 1024) while in_ready stays low; configuration writes
//   are still taken. When the receiver stalls, up to three results queue
//   before in_ready drops; no result is lost.
module dense_id_renaming_table #(
  parameter int MAX_VARS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dirt_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dirt_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [dirt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dirt_pkg::LIM_W-1:0]        cfg_wdata
);
  import dirt_pkg::*;

  localparam int TBL_DEPTH = (MAX_VARS < 1024) ? MAX_VARS : 1024;
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TBL_DEPTH - 1);

  // Sequencer states
  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_CLEAR = 1'b1;

  logic                state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [LIM_W-1:0]    count_r, count_nxt;
  logic [LIM_W-1:0]    first_temp_r;
  logic [LIM_W-1:0]    old_limit_r;

  logic                p1_valid_r;
  in_item_t            p1_item_r;

  logic                wr_valid_r;
  logic [AW-1:0]       wr_addr_r;
  tbl_entry_t          wr_data_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  tbl_entry_t          ram_wdata;
  logic [TBL_W-1:0]    ram_rdata;
  tbl_entry_t          rd_entry;
  tbl_entry_t          cur_entry;

  logic                in_acc;
  logic                fwd_hit;
  logic                hit;
  logic                elig;
  logic                is_finish;
  logic                wrap;
  logic [LIM_W:0]      dense_sum;
  logic [ID_W-1:0]     dense_id;
  logic [LIM_W-1:0]    new_limit;
  logic                assign_new;
  out_item_t           rsp;
  logic [FIFO_CW-1:0]  fifo_cnt;

  // Accept only with queue room and no clearing pass pending
  assign is_finish = p1_valid_r && (p1_item_r.req_type == REQ_FINISH);
  assign wrap      = is_finish && (epoch_r == EPOCH_MAX);
  assign in_ready  = (state_r == ST_RUN) && !wrap &&
                     ((fifo_cnt + FIFO_CW'(p1_valid_r)) <= FIFO_CW'(2));
  assign in_acc    = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_temp_r <= '0;
      old_limit_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_TEMP: first_temp_r <= cfg_wdata;
        CFG_OLD_LIMIT:  old_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Lookup stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_item_r <= in_data;
    end
  end

  // Table memory
  dirt_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_data.var_id[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Forward the word written last cycle over the stale read
  assign rd_entry  = tbl_entry_t'(ram_rdata);
  assign fwd_hit   = wr_valid_r && (wr_addr_r == p1_item_r.var_id[AW-1:0]);
  assign cur_entry = fwd_hit ? wr_data_r : rd_entry;
  assign hit       = (cur_entry.epoch == epoch_r);

  // Decide whether the operand is a renameable temporary
  assign elig = p1_valid_r && (p1_item_r.req_type == REQ_OPERAND) &&
                p1_item_r.is_variable &&
                ({1'b0, p1_item_r.var_id} >= first_temp_r) &&
                (old_limit_r != first_temp_r) &&
                ({22'd0, p1_item_r.var_id} < 32'(MAX_VARS));
  assign assign_new = elig && !hit;

  // Next dense identifier and new limit, both saturating
  assign dense_sum = {1'b0, first_temp_r} + {1'b0, count_r};
  assign dense_id  = (dense_sum > (LIM_W+1)'(ID_MAX)) ? ID_MAX : dense_sum[ID_W-1:0];
  assign new_limit = dense_sum[LIM_W] ? LIM_MAX : dense_sum[LIM_W-1:0];

  // Build the result item
  always_comb begin
    rsp = '0;
    if (is_finish) begin
      rsp.new_var_limit = new_limit;
      rsp.var_gain      = (old_limit_r > new_limit) ? (old_limit_r - new_limit) : '0;
    end else begin
      rsp.id_out = p1_item_r.var_id;
      if (elig) begin
        rsp.id_out         = hit ? cur_entry.mapped : dense_id;
        rsp.id_changed     = (rsp.id_out != p1_item_r.var_id);
        rsp.newly_assigned = !hit;
      end
    end
  end

  // Table write: clearing pass or a new entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p1_item_r.var_id[AW-1:0];
    ram_wdata = '{epoch: epoch_r, mapped: dense_id};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (assign_new) begin
      ram_we = 1'b1;
    end
  end

  // Hold the last write for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_valid_r <= 1'b0;
    end else begin
      wr_valid_r <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= ram_waddr;
    wr_data_r <= ram_wdata;
  end

  // Count, epoch and clearing sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    epoch_nxt    = epoch_r;
    count_nxt    = count_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt    = ST_RUN;
          clr_addr_nxt = '0;
        end
      end
      ST_RUN: begin
        if (is_finish) begin
          count_nxt = '0;
          if (wrap) begin
            state_nxt    = ST_CLEAR;
            clr_addr_nxt = '0;
            epoch_nxt    = EPOCH_W'(1);
          end else begin
            epoch_nxt = epoch_r + 1'b1;
          end
        end else if (assign_new && (count_r != LIM_MAX)) begin
          count_nxt = count_r + 1'b1;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      epoch_r    <= EPOCH_W'(1);
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      epoch_r    <= epoch_nxt;
      count_r    <= count_nxt;
    end
  end

  // Result queue
  dirt_rsp_fifo u_rsp_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (p1_valid_r),
    .push_data (rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_cnt)
  );

  // A finish at the last epoch starts a clearing pass
  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    wrap |=> (state_r == ST_CLEAR))
    else $error("clearing pass not started after epoch wrap");

  // No item sits in the lookup stage while the pass owns the write port
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !p1_valid_r)
    else $error("item in lookup stage during clearing pass");

  // Epoch zero marks cleared entries and is never current
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("current epoch is zero");

  // The result queue never overflows
  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> (fifo_cnt < FIFO_CW'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // A new entry advances the count by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && assign_new && count_r != LIM_MAX)
      |=> (count_r == $past(count_r) + 1'b1))
    else $error("count did not advance on new entry");

endmodule

[tb/dense_id_renaming_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for dense_id_renaming_table: random and directed
// operand/finish items against a cycle-free predictor. Depends on dirt_pkg.
module dense_id_renaming_table_tb;
  import dirt_pkg::*;

  localparam int MAX_VARS    = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 8;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_TEMP;
  logic [LIM_W-1:0]     cfg_wdata = '0;

  // Predictor state: rename table, entry flags, temporary count, registers
  logic [ID_W-1:0]  rename_map [MAX_VARS];
  bit               map_valid  [MAX_VARS];
  logic [LIM_W-1:0] temp_cnt   = '0;
  logic [LIM_W-1:0] first_temp = '0;
  logic [LIM_W-1:0] old_limit  = '0;

  in_item_t  stim_q[$];
  out_item_t result_q[$];
  int        n_queued       = 0;
  int        n_accepted     = 0;
  int        err_count      = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        cycle_cnt      = 0;

  dense_id_renaming_table #(.MAX_VARS(MAX_VARS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Compute the result of one item and advance the table state
  function automatic out_item_t rename_item(in_item_t it);
    out_item_t        r;
    logic [LIM_W:0]   sum;
    r   = '0;
    sum = {1'b0, first_temp} + {1'b0, temp_cnt};
    if (it.req_type == REQ_FINISH) begin
      r.new_var_limit = (sum > {1'b0, LIM_MAX}) ? LIM_MAX : sum[LIM_W-1:0];
      r.var_gain      = (old_limit > r.new_var_limit) ? old_limit - r.new_var_limit : '0;
      foreach (map_valid[k]) map_valid[k] = 1'b0;
      temp_cnt = '0;
    end else begin
      r.id_out = it.var_id;
      if (it.is_variable && {1'b0, it.var_id} >= first_temp &&
          old_limit != first_temp && int'(it.var_id) < MAX_VARS) begin
        // First sighting takes the next dense identifier, saturated
        if (!map_valid[it.var_id]) begin
          rename_map[it.var_id] = (sum > ID_MAX) ? ID_MAX : sum[ID_W-1:0];
          map_valid[it.var_id]  = 1'b1;
          if (temp_cnt != LIM_MAX) temp_cnt = temp_cnt + 1'b1;
          r.newly_assigned = 1'b1;
        end
        r.id_out     = rename_map[it.var_id];
        r.id_changed = (r.id_out != it.var_id);
      end
    end
    return r;
  endfunction

  function automatic void push_op(logic is_var, logic [ID_W-1:0] vid);
    in_item_t it;
    it.req_type    = REQ_OPERAND;
    it.is_variable = is_var;
    it.var_id      = vid;
    stim_q.push_back(it);
    n_queued++;
  endfunction

  function automatic void push_finish();
    in_item_t it;
    it.req_type    = REQ_FINISH;
    it.is_variable = 1'($urandom_range(1, 0));
    it.var_id      = ID_W'($urandom_range(1023, 0));
    stim_q.push_back(it);
    n_queued++;
  endfunction

  // Write both registers; only called while nothing is in flight
  task automatic set_regs(logic [LIM_W-1:0] first_id, logic [LIM_W-1:0] old_lim);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_TEMP;
    cfg_wdata <= first_id;
    @(posedge clk);
    cfg_index <= CFG_OLD_LIMIT;
    cfg_wdata <= old_lim;
    @(posedge clk);
    cfg_we     <= 1'b0;
    first_temp = first_id;
    old_limit  = old_lim;
  endtask

  // Hold until every queued item is taken and every result has come back
  task automatic wait_idle();
    do @(posedge clk); while (n_accepted != n_queued || result_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Queue methods: operand runs with repeats, then usually a finish
  task automatic run_methods(int n_items);
    logic [ID_W-1:0] seen[$];
    logic [ID_W-1:0] vid;
    int              lo;
    int              pick;
    int              len;
    int              made;
    made = 0;
    lo   = (first_temp > 1023) ? 0 : int'(first_temp);
    while (made < n_items) begin
      len = $urandom_range(24, 0);
      seen.delete();
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(99, 0);
        if (seen.size() > 0 && pick < 15) begin
          vid = seen[seen.size()-1];
        end else if (seen.size() > 0 && pick < 45) begin
          vid = seen[$urandom_range(seen.size()-1, 0)];
        end else if (pick < 85) begin
          vid = ID_W'($urandom_range(1023, lo));
        end else begin
          vid = ID_W'($urandom_range(1023, 0));
        end
        seen.push_back(vid);
        push_op($urandom_range(99, 0) < 90, vid);
        // stray finish breaking a method in the middle
        if ($urandom_range(49, 0) == 0) push_finish();
      end
      // leave some methods open across a register change
      if ($urandom_range(9, 0) != 0) push_finish();
      made += len + 1;
    end
  endtask

  // Driver: present queued items, predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        result_q.push_back(rename_item(in_data));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (stim_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_data  <= stim_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result item: id_out %0d new_var_limit %0d",
                 out_data.id_out, out_data.new_var_limit);
          err_count++;
        end else begin
          want = result_q.pop_front();
          if (out_data.id_out !== want.id_out) begin
            $error("id_out: expected %0d, got %0d", want.id_out, out_data.id_out);
            err_count++;
          end
          if (out_data.id_changed !== want.id_changed) begin
            $error("id_changed: expected %0d, got %0d", want.id_changed, out_data.id_changed);
            err_count++;
          end
          if (out_data.newly_assigned !== want.newly_assigned) begin
            $error("newly_assigned: expected %0d, got %0d",
                   want.newly_assigned, out_data.newly_assigned);
            err_count++;
          end
          if (out_data.new_var_limit !== want.new_var_limit) begin
            $error("new_var_limit: expected %0d, got %0d",
                   want.new_var_limit, out_data.new_var_limit);
            err_count++;
          end
          if (out_data.var_gain !== want.var_gain) begin
            $error("var_gain: expected %0d, got %0d", want.var_gain, out_data.var_gain);
            err_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Watchdog: covers the clearing passes and the slowest idle phases
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [ID_W-1:0] order [MAX_VARS];
    logic [ID_W-1:0] tmp;
    int              j;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // No temporaries: everything passes through
    set_regs(0, 0);
    push_op(1'b1, 0);
    push_op(1'b1, 1023);
    push_op(1'b0, 7);
    push_finish();
    wait_idle();

    // Below the first temporary, new entries, back-to-back repeat, constant
    set_regs(4, 1024);
    push_op(1'b1, 3);
    push_op(1'b1, 4);
    push_op(1'b1, 1023);
    push_op(1'b1, 1023);
    push_op(1'b0, 1023);
    push_op(1'b1, 4);
    push_finish();
    push_finish();
    wait_idle();

    // First temporary beyond every identifier
    set_regs(1024, 0);
    push_op(1'b1, 1023);
    push_finish();
    wait_idle();

    // Dense identifier overflow after a register change mid-method
    set_regs(0, 1);
    push_op(1'b1, 0);
    push_op(1'b1, 1);
    push_op(1'b1, 2);
    wait_idle();
    set_regs(1022, 0);
    push_op(1'b1, 1022);
    push_op(1'b1, 1023);
    push_finish();
    wait_idle();

    // Fill the whole table in shuffled order, then saturate the new limit
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    set_regs(0, 1);
    push_finish();
    foreach (order[k]) order[k] = ID_W'(k);
    for (int k = MAX_VARS - 1; k > 0; k--) begin
      j        = $urandom_range(k, 0);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) push_op(1'b1, order[k]);
    wait_idle();
    set_regs(1024, 1024);
    push_op(1'b1, 1023);
    push_finish();
    wait_idle();

    // Random methods across idle modes and register settings
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      case (p)
        0: set_regs(0, 1024);
        1: set_regs(1024, 0);
        2: set_regs(0, 0);
        3: set_regs(1024, 1024);
        default: set_regs(($urandom_range(3, 0) == 0) ? LIM_W'($urandom_range(1024, 0))
                                                      : LIM_W'($urandom_range(96, 0)),
                          LIM_W'($urandom_range(1024, 0)));
      endcase
      run_methods(80);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
